// File: rtl/core/apts_pkg.sv
// ----------------------------------------------------------------------------
// apts_pkg: shared definitions of the aging priority task scheduler
// Command and status codes, priority limits, widths and the compare key.
// ----------------------------------------------------------------------------
package apts_pkg;

    localparam int NUM_TASKS_DEF = 16;
    localparam int CMD_W         = 3;
    localparam int TASK_W        = 4;
    localparam int PRIO_IN_W     = 7;
    localparam int PRIO_W        = 6;
    localparam int QUANT_W       = 8;
    localparam int CNT_W         = 32;
    localparam int STATUS_W      = 2;

    localparam logic [QUANT_W-1:0] QUANT_RESET = 8'd20;

    localparam logic signed [PRIO_W-1:0] PRIO_MAX = 6'sd20;
    localparam logic signed [PRIO_W-1:0] PRIO_MIN = -6'sd20;

    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RESUME  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUSPEND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SETPRIO = 3'd3;
    localparam logic [CMD_W-1:0] CMD_YIELD   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TICK    = 3'd5;
    localparam logic [CMD_W-1:0] CMD_EXIT    = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPRIO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;

    // One entry as seen by the shared compare unit.
    typedef struct packed {
        logic signed [PRIO_W-1:0] dyn;
        logic signed [PRIO_W-1:0] stat;
        logic [7:0]               rank;
    } apts_key_t;

endpackage

// File: rtl/core/apts_cmp.sv
// ----------------------------------------------------------------------------
// apts_cmp: shared compare unit of the pick scan
// Tells whether a candidate entry beats the best entry found so far.
// ----------------------------------------------------------------------------
module apts_cmp
(
    input  apts_pkg::apts_key_t cand,
    input  apts_pkg::apts_key_t best,
    input  logic                found,
    output logic                better
);
    import apts_pkg::*;

    always_comb
    begin
        better = !found || (cand.dyn < best.dyn) ||
                 (cand.dyn == best.dyn && (cand.stat < best.stat ||
                  (cand.stat == best.stat && cand.rank < best.rank)));
    end

endmodule

// File: rtl/core/aging_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// aging_priority_task_scheduler: priority scheduler with aging
// Keeps the ready queue, the running task and per-task counters, and answers
// each command word with one status word.
// ----------------------------------------------------------------------------
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+----------
//  in      | in_valid in_ready cmd task_req prio       | input
//  out     | out_valid out_ready current_task ...      | output
//  cfg     | cfg_valid cfg_ready cfg_data              | input
//
// A command word that leads to a pick keeps the block busy through the entry
// scan, which walks the task table one entry a cycle through one compare unit
// for the selection and again for aging and queue renumbering; any other
// command skips the scan.
// Reset clears the ready mask, running state, quantum and tick counter.
// A result waits in the output register; the next command word is taken as
// soon as the block returns to idle, even while that result is stalled, and
// that command then waits before its own result until the stalled word leaves.
module aging_priority_task_scheduler
    import apts_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [CMD_W-1:0]            cmd,
    input  logic [TASK_W-1:0]           task_req,
    input  logic signed [PRIO_IN_W-1:0] prio,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [TASK_W-1:0]           current_task,
    output logic                        current_valid,
    output logic                        switched,
    output logic [STATUS_W-1:0]         status,
    output logic [CNT_W-1:0]            system_ticks,
    output logic [CNT_W-1:0]            task_run_ticks,
    output logic [CNT_W-1:0]            task_activations,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [QUANT_W-1:0]          cfg_data
);

    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam int SW = IW + 1;
    localparam logic [SW-1:0] LAST = SW'(NUM_TASKS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_AGE  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] S_RSLT = 3'd5;
    localparam logic [2:0] S_CHK  = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [NUM_TASKS-1:0]       ready_reg;
    logic [CW-1:0]              rcount_reg;
    logic [IW-1:0]              run_idx_reg;
    logic                       run_valid_reg;
    logic [QUANT_W-1:0]         qleft_reg;
    logic [QUANT_W-1:0]         qlen_reg;
    logic [CNT_W-1:0]           ticks_reg;

    logic signed [PRIO_W-1:0]   spr_reg [NUM_TASKS];
    logic signed [PRIO_W-1:0]   dpr_reg [NUM_TASKS];
    logic [CW-1:0]              rank_reg [NUM_TASKS];
    logic [CNT_W-1:0]           runt_reg [NUM_TASKS];
    logic [CNT_W-1:0]           act_reg [NUM_TASKS];

    logic [CMD_W-1:0]           c_reg;
    logic [TASK_W-1:0]          t_reg;
    logic signed [PRIO_IN_W-1:0] p_reg;
    logic [STATUS_W-1:0]        st_reg;
    logic                       sw_reg;

    // Scan bookkeeping: index, best entry so far and the key of that entry.
    logic [SW-1:0]              idx_reg;
    logic [IW-1:0]              best_reg;
    logic                       found_reg;
    apts_key_t                  bkey_reg;

    logic                       o_valid_reg;
    logic [TASK_W-1:0]          o_task_reg;
    logic                       o_cv_reg;
    logic                       o_sw_reg;
    logic [STATUS_W-1:0]        o_st_reg;
    logic [CNT_W-1:0]           o_sys_reg;
    logic [CNT_W-1:0]           o_run_reg;
    logic [CNT_W-1:0]           o_act_reg;

    logic [IW-1:0]  ci;
    apts_key_t      ckey;
    logic           better;
    logic           t_ok;
    logic [IW-1:0]  ti;
    logic           p_bad;

    assign ci = idx_reg[IW-1:0];
    assign t_ok = ({28'd0, t_reg} < 32'(NUM_TASKS));
    assign ti = IW'(t_reg);
    assign p_bad = (p_reg > PRIO_MAX) || (p_reg < PRIO_MIN);

    always_comb
    begin
        ckey.dyn  = dpr_reg[ci];
        ckey.stat = spr_reg[ci];
        ckey.rank = 8'(rank_reg[ci]);
    end

    apts_cmp u_cmp
    (
        .cand   (ckey),
        .best   (bkey_reg),
        .found  (found_reg),
        .better (better)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_EXEC;
            S_EXEC: state_next = S_CHK;
            // With nothing running after the command and a task ready, a pick follows.
            S_CHK:  state_next = (!run_valid_reg && ready_reg != '0) ? S_SCAN : S_DONE;
            S_SCAN: if (idx_reg == LAST) state_next = S_AGE;
            S_AGE:  if (idx_reg == LAST) state_next = S_DONE;
            S_DONE: state_next = S_RSLT;
            S_RSLT: if (!o_valid_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        logic run_v;
        logic [NUM_TASKS-1:0] rdy;
        logic [CW-1:0] rc;
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ready_reg     <= '0;
            rcount_reg    <= '0;
            run_idx_reg   <= '0;
            run_valid_reg <= 1'b0;
            qleft_reg     <= '0;
            qlen_reg      <= QUANT_RESET;
            ticks_reg     <= '0;
            o_valid_reg   <= 1'b0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_RSLT && (!o_valid_reg || out_ready)) o_valid_reg <= 1'b1;
            else if (out_ready) o_valid_reg <= 1'b0;
            if (cfg_valid && cfg_ready) qlen_reg <= cfg_data;
            unique case (state_reg)
                S_EXEC:
                begin
                    run_v = run_valid_reg;
                    rdy   = ready_reg;
                    rc    = rcount_reg;
                    unique case (c_reg)
                        CMD_CREATE:
                            if (t_ok && !rdy[ti] && !(run_v && run_idx_reg == ti))
                            begin
                                rdy[ti] = 1'b1;
                                rc = rc + 1'b1;
                            end
                        CMD_RESUME:
                            if (t_ok && !(run_v && run_idx_reg == ti))
                            begin
                                if (!rdy[ti]) rc = rc + 1'b1;
                                rdy[ti] = 1'b1;
                            end
                        CMD_SUSPEND:
                            if (t_ok)
                            begin
                                if (rdy[ti])
                                begin
                                    rdy[ti] = 1'b0;
                                    rc = rc - 1'b1;
                                end
                                else if (run_v && run_idx_reg == ti) run_v = 1'b0;
                            end
                        CMD_YIELD:
                        begin
                            if (run_v)
                            begin
                                rdy[run_idx_reg] = 1'b1;
                                rc = rc + 1'b1;
                            end
                            run_v = 1'b0;
                        end
                        CMD_TICK:
                        begin
                            ticks_reg <= ticks_reg + 1'b1;
                            if (run_v)
                            begin
                                if (qleft_reg <= 8'd1)
                                begin
                                    qleft_reg <= '0;
                                    rdy[run_idx_reg] = 1'b1;
                                    rc = rc + 1'b1;
                                    run_v = 1'b0;
                                end
                                else qleft_reg <= qleft_reg - 1'b1;
                            end
                        end
                        CMD_EXIT: run_v = 1'b0;
                        default: ;
                    endcase
                    ready_reg     <= rdy;
                    rcount_reg    <= rc;
                    run_valid_reg <= run_v;
                    idx_reg       <= '0;
                    found_reg     <= 1'b0;
                end
                S_SCAN:
                begin
                    if (ready_reg[ci] && better) found_reg <= 1'b1;
                    idx_reg <= (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
                end
                S_AGE:
                begin
                    idx_reg <= (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
                    if (idx_reg == LAST)
                    begin
                        ready_reg[best_reg] <= 1'b0;
                        rcount_reg    <= rcount_reg - 1'b1;
                        run_idx_reg   <= best_reg;
                        run_valid_reg <= 1'b1;
                        qleft_reg     <= qlen_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // Per-task tables, scan registers and result payload.
    always_ff @(posedge clk)
    begin
        logic [CW-1:0] br;
        br = rank_reg[best_reg];
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    c_reg <= cmd;
                    t_reg <= task_req;
                    p_reg <= prio;
                end
            S_EXEC:
            begin
                st_reg <= (c_reg == CMD_SETPRIO && p_bad) ? ST_BADPRIO : ST_OK;
                sw_reg <= 1'b0;
                unique case (c_reg)
                    CMD_CREATE:
                        if (t_ok)
                        begin
                            spr_reg[ti]  <= '0;
                            dpr_reg[ti]  <= '0;
                            runt_reg[ti] <= '0;
                            act_reg[ti]  <= '0;
                            if (!ready_reg[ti] && !(run_valid_reg && run_idx_reg == ti))
                                rank_reg[ti] <= rcount_reg;
                        end
                    CMD_RESUME:
                        if (t_ok && !(run_valid_reg && run_idx_reg == ti))
                        begin
                            // Moving to the tail: if it was already queued, ranks above drop by one.
                            for (int i = 0; i < NUM_TASKS; i++)
                                if (ready_reg[i] && ready_reg[ti] &&
                                    rank_reg[i] > rank_reg[ti])
                                    rank_reg[i] <= rank_reg[i] - 1'b1;
                            rank_reg[ti] <= ready_reg[ti] ? rcount_reg - 1'b1
                                                          : rcount_reg;
                        end
                    CMD_SUSPEND:
                        if (t_ok && ready_reg[ti])
                            for (int i = 0; i < NUM_TASKS; i++)
                                if (ready_reg[i] && rank_reg[i] > rank_reg[ti])
                                    rank_reg[i] <= rank_reg[i] - 1'b1;
                    CMD_SETPRIO:
                        if (!p_bad && t_ok)
                        begin
                            spr_reg[ti] <= PRIO_W'(p_reg);
                            dpr_reg[ti] <= PRIO_W'(p_reg);
                        end
                    CMD_YIELD:
                        if (run_valid_reg) rank_reg[run_idx_reg] <= rcount_reg;
                    CMD_TICK:
                        if (run_valid_reg)
                        begin
                            runt_reg[run_idx_reg] <= runt_reg[run_idx_reg] + 1'b1;
                            if (qleft_reg <= 8'd1) rank_reg[run_idx_reg] <= rcount_reg;
                        end
                    default: ;
                endcase
            end
            S_SCAN:
                if (ready_reg[ci] && better)
                begin
                    best_reg <= ci;
                    bkey_reg <= ckey;
                end
            S_AGE:
            begin
                if (ci == best_reg)
                begin
                    dpr_reg[ci] <= spr_reg[ci];
                    act_reg[ci] <= act_reg[ci] + 1'b1;
                    sw_reg      <= 1'b1;
                end
                else if (ready_reg[ci])
                begin
                    if (dpr_reg[ci] > PRIO_MIN) dpr_reg[ci] <= dpr_reg[ci] - 1'b1;
                    if (rank_reg[ci] > br) rank_reg[ci] <= rank_reg[ci] - 1'b1;
                end
            end
            S_DONE:
                if (!run_valid_reg && st_reg == ST_OK) st_reg <= ST_EMPTY;
            S_RSLT:
                if (!o_valid_reg || out_ready)
                begin
                    o_task_reg <= run_valid_reg ? TASK_W'(run_idx_reg) : '0;
                    o_cv_reg   <= run_valid_reg;
                    o_sw_reg   <= sw_reg;
                    o_st_reg   <= st_reg;
                    o_sys_reg  <= ticks_reg;
                    o_run_reg  <= t_ok ? runt_reg[ti] : '0;
                    o_act_reg  <= t_ok ? act_reg[ti] : '0;
                end
            default: ;
        endcase
    end

    assign out_valid        = o_valid_reg;
    assign current_task     = o_task_reg;
    assign current_valid    = o_cv_reg;
    assign switched         = o_sw_reg;
    assign status           = o_st_reg;
    assign system_ticks     = o_sys_reg;
    assign task_run_ticks   = o_run_reg;
    assign task_activations = o_act_reg;

endmodule

// File: rtl/core/apts_checker.sv
// ----------------------------------------------------------------------------
// apts_checker: port-level checks of the scheduler
// Watches the top-level ports and flags inconsistent result words.
// ----------------------------------------------------------------------------
module apts_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] current_task,
    input logic       current_valid,
    input logic       switched,
    input logic [1:0] status
);
    import apts_pkg::*;

    // A dispatch always leaves a task running.
    a_sw_runs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && switched |-> current_valid)
        else $error("switch without running task");

    // Empty status only when idle.
    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> !current_valid)
        else $error("empty status with running task");

    // Idle reports task zero.
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !current_valid |-> current_task == 4'd0)
        else $error("idle result names a task");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("stalled result changed");

    // A taken command word keeps the input busy in the next cycle.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a command word");

endmodule

bind aging_priority_task_scheduler apts_checker u_apts_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .current_task  (current_task),
    .current_valid (current_valid),
    .switched      (switched),
    .status        (status)
);
